// File: rtl/core/sieve_spf_factorizer_top_macros.svh
`ifndef SIEVE_SPF_FACTORIZER_TOP_MACROS_SVH
`define SIEVE_SPF_FACTORIZER_TOP_MACROS_SVH

// Same-cycle implication check, disabled while reset is asserted.
`define SSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication check, disabled while reset is asserted.
`define SSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: rtl/core/ssf_pkg.sv
package ssf_pkg;

  localparam int VAL_W     = 16;
  localparam int CNT_W     = VAL_W + 1;
  localparam int EXP_W     = 5;
  localparam int ST_W      = 2;
  localparam int MAX_RES   = 6;
  localparam int K_W       = 3;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam logic OP_BUILD = 1'b0;

  localparam logic [ST_W-1:0] ST_FACTOR = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE   = 2'd2;
  localparam logic [ST_W-1:0] ST_ERROR  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/ssf_div.sv
module ssf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ssf_pkg::div_req_t req,
  output ssf_pkg::div_rsp_t rsp
);

  logic                            run_r;
  logic                            done_r;
  logic [ssf_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [ssf_pkg::VAL_W-1:0]       rem_r;
  logic [ssf_pkg::VAL_W-1:0]       quo_r;
  logic [ssf_pkg::VAL_W-1:0]       dvs_r;
  logic [ssf_pkg::VAL_W:0]         shift_w;
  logic [ssf_pkg::VAL_W:0]         diff_w;
  logic                            ge_w;
  logic [ssf_pkg::VAL_W-1:0]       rem_nxt;
  logic [ssf_pkg::VAL_W-1:0]       quo_nxt;

  // Restoring division, one quotient bit per cycle. The remainder stays below
  // the divisor, so it always fits in the dividend width.
  assign shift_w = {rem_r, quo_r[ssf_pkg::VAL_W-1]};
  assign ge_w    = shift_w >= {1'b0, dvs_r};
  assign diff_w  = shift_w - {1'b0, dvs_r};
  assign rem_nxt = ge_w ? diff_w[ssf_pkg::VAL_W-1:0] : shift_w[ssf_pkg::VAL_W-1:0];
  assign quo_nxt = {quo_r[ssf_pkg::VAL_W-2:0], ge_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + ssf_pkg::DIV_CNT_W'(1);
        if (cnt_r == ssf_pkg::DIV_CNT_W'(ssf_pkg::VAL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: rtl/core/sieve_spf_factorizer_top.sv
// Factorize: error and empty results come in the cycle after the request; otherwise the table
// is read and the shared divider divides by each prime factor in turn, at most 15 divisions.
// Build: clears entries 0 to limit, then reads each candidate; an unmarked one is a prime, which
// writes itself and then each still unmarked multiple; one done result at the end.
// busy is high meanwhile. Results are one-cycle strobes and are never held off.
// Reset clears control and sets limit to 65535; factorize gives errors until a build.
`include "sieve_spf_factorizer_top_macros.svh"

module sieve_spf_factorizer_top #(
  parameter int unsigned MAX_VALUE = 65535
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [ssf_pkg::VAL_W-1:0]    in_value,
  input  logic                         cfg_we,
  input  logic [ssf_pkg::VAL_W-1:0]    cfg_wdata,
  output logic                         out_valid,
  output logic [ssf_pkg::VAL_W-1:0]    out_prime,
  output logic [ssf_pkg::EXP_W-1:0]    out_exponent,
  output logic                         out_last,
  output logic [ssf_pkg::ST_W-1:0]     out_status
);

  localparam int unsigned DEPTH   = MAX_VALUE + 1;
  localparam int          AW      = $clog2(DEPTH);
  localparam int unsigned CAP_INT = (MAX_VALUE > 65535) ? 65535 : MAX_VALUE;
  localparam logic [ssf_pkg::VAL_W-1:0] LIM_CAP = ssf_pkg::VAL_W'(CAP_INT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_PTEST = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_QTEST = 4'd4;
  localparam logic [3:0] S_QCHK  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_NRD   = 4'd9;
  localparam logic [3:0] S_NCHK  = 4'd10;

  logic [3:0]                    state_r, state_nxt;
  logic [ssf_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ssf_pkg::CNT_W-1:0]     q_r, q_nxt;
  logic [ssf_pkg::VAL_W-1:0]     n_r, n_nxt;
  logic [ssf_pkg::VAL_W-1:0]     curp_r, curp_nxt;
  logic [ssf_pkg::EXP_W-1:0]     exp_r, exp_nxt;
  logic [ssf_pkg::K_W-1:0]       k_r, k_nxt;
  logic [ssf_pkg::VAL_W-1:0]     blim_r, blim_nxt;
  logic                          built_r, built_nxt;
  logic [ssf_pkg::VAL_W-1:0]     limit_r;
  logic [ssf_pkg::VAL_W-1:0]     lim_eff;

  logic [ssf_pkg::VAL_W-1:0]     fac_mem_r [0:DEPTH-1];
  logic [ssf_pkg::VAL_W-1:0]     rdata_r;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [ssf_pkg::VAL_W-1:0]     mem_wdata;

  logic [ssf_pkg::CNT_W-1:0]     add_a, add_b, add_sum;
  logic [ssf_pkg::EXP_W-1:0]     exp_inc;
  logic                          nchk_last;

  ssf_pkg::div_req_t             div_req;
  ssf_pkg::div_rsp_t             div_rsp;

  logic                          emit;
  logic [ssf_pkg::VAL_W-1:0]     e_prime;
  logic [ssf_pkg::EXP_W-1:0]     e_exp;
  logic                          e_last;
  logic [ssf_pkg::ST_W-1:0]      e_status;

  logic                          out_valid_r;
  logic [ssf_pkg::VAL_W-1:0]     out_prime_r;
  logic [ssf_pkg::EXP_W-1:0]     out_exp_r;
  logic                          out_last_r;
  logic [ssf_pkg::ST_W-1:0]      out_status_r;

  ssf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign lim_eff   = (limit_r > LIM_CAP) ? LIM_CAP : limit_r;
  // One adder serves the candidate counter and the multiple stepping.
  assign add_sum   = add_a + add_b;
  assign exp_inc   = exp_r + ssf_pkg::EXP_W'(1);
  // A new table entry below two or the sixth distinct prime ends the walk.
  assign nchk_last = (rdata_r < ssf_pkg::VAL_W'(2)) ||
                     (k_r == ssf_pkg::K_W'(ssf_pkg::MAX_RES - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    curp_nxt  = curp_r;
    exp_nxt   = exp_r;
    k_nxt     = k_r;
    blim_nxt  = blim_r;
    built_nxt = built_r;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    add_a     = '0;
    add_b     = '0;
    div_req   = '0;
    emit      = 1'b0;
    e_prime   = '0;
    e_exp     = '0;
    e_last    = 1'b1;
    e_status  = ssf_pkg::ST_FACTOR;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == ssf_pkg::OP_BUILD) begin
            blim_nxt  = lim_eff;
            cnt_nxt   = '0;
            state_nxt = S_CLR;
          end else if (!built_r ||
                       (in_value > ssf_pkg::VAL_W'(1) && in_value > blim_r)) begin
            emit     = 1'b1;
            e_status = ssf_pkg::ST_ERROR;
          end else if (in_value <= ssf_pkg::VAL_W'(1)) begin
            emit     = 1'b1;
            e_status = ssf_pkg::ST_EMPTY;
          end else begin
            n_nxt     = in_value;
            k_nxt     = '0;
            state_nxt = S_FRD;
          end
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = (cnt_r == ssf_pkg::CNT_W'(1)) ? ssf_pkg::VAL_W'(1) : '0;
        add_a     = cnt_r;
        add_b     = ssf_pkg::CNT_W'(1);
        if (cnt_r[ssf_pkg::VAL_W-1:0] == blim_r) begin
          cnt_nxt   = ssf_pkg::CNT_W'(2);
          state_nxt = S_PTEST;
        end else begin
          cnt_nxt = add_sum;
        end
      end
      S_PTEST: begin
        if (cnt_r > {1'b0, blim_r}) begin
          emit      = 1'b1;
          e_status  = ssf_pkg::ST_DONE;
          built_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_addr   = AW'(cnt_r);
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        add_a = cnt_r;
        if (rdata_r == '0) begin
          // Unmarked candidate is prime: it takes itself, then its still unmarked multiples.
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_r);
          mem_wdata = cnt_r[ssf_pkg::VAL_W-1:0];
          add_b     = cnt_r;
          q_nxt     = add_sum;
          state_nxt = S_QTEST;
        end else begin
          add_b     = ssf_pkg::CNT_W'(1);
          cnt_nxt   = add_sum;
          state_nxt = S_PTEST;
        end
      end
      S_QTEST: begin
        if (q_r > {1'b0, blim_r}) begin
          add_a     = cnt_r;
          add_b     = ssf_pkg::CNT_W'(1);
          cnt_nxt   = add_sum;
          state_nxt = S_PTEST;
        end else begin
          rd_addr   = AW'(q_r);
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (rdata_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(q_r);
          mem_wdata = cnt_r[ssf_pkg::VAL_W-1:0];
        end
        add_a     = q_r;
        add_b     = cnt_r;
        q_nxt     = add_sum;
        state_nxt = S_QTEST;
      end
      S_FRD: begin
        rd_addr   = AW'(n_r);
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (rdata_r < ssf_pkg::VAL_W'(2)) begin
          emit      = 1'b1;
          e_status  = ssf_pkg::ST_ERROR;
          state_nxt = S_IDLE;
        end else begin
          curp_nxt         = rdata_r;
          exp_nxt          = '0;
          div_req.start    = 1'b1;
          div_req.dividend = n_r;
          div_req.divisor  = rdata_r;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          n_nxt   = div_rsp.quotient;
          exp_nxt = exp_inc;
          if (div_rsp.quotient == ssf_pkg::VAL_W'(1)) begin
            emit      = 1'b1;
            e_prime   = curp_r;
            e_exp     = exp_inc;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NRD;
          end
        end
      end
      S_NRD: begin
        rd_addr   = AW'(n_r);
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        if (rdata_r == curp_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = n_r;
          div_req.divisor  = curp_r;
          state_nxt        = S_DIV;
        end else begin
          emit    = 1'b1;
          e_prime = curp_r;
          e_exp   = exp_r;
          e_last  = nchk_last;
          k_nxt   = k_r + ssf_pkg::K_W'(1);
          if (nchk_last) begin
            state_nxt = S_IDLE;
          end else begin
            curp_nxt         = rdata_r;
            exp_nxt          = '0;
            div_req.start    = 1'b1;
            div_req.dividend = n_r;
            div_req.divisor  = rdata_r;
            state_nxt        = S_DIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      limit_r     <= ssf_pkg::VAL_W'(65535);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      out_valid_r <= emit;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    n_r    <= n_nxt;
    curp_r <= curp_nxt;
    exp_r  <= exp_nxt;
    k_r    <= k_nxt;
    blim_r <= blim_nxt;
    if (emit) begin
      out_prime_r  <= e_prime;
      out_exp_r    <= e_exp;
      out_last_r   <= e_last;
      out_status_r <= e_status;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fac_mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= fac_mem_r[rd_addr];
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_prime    = out_prime_r;
  assign out_exponent = out_exp_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

  `SSF_ASSERT_IMP(a_nonlast_is_factor, clk, rst_n, out_valid && !out_last, out_status == ssf_pkg::ST_FACTOR)
  `SSF_ASSERT_IMP(a_factor_payload, clk, rst_n, out_valid && out_status == ssf_pkg::ST_FACTOR, out_exponent != '0 && out_prime >= ssf_pkg::VAL_W'(2))
  `SSF_ASSERT_IMP(a_other_payload, clk, rst_n, out_valid && out_status != ssf_pkg::ST_FACTOR, out_prime == '0 && out_exponent == '0 && out_last)
  `SSF_ASSERT_NXT(a_build_goes_busy, clk, rst_n, start && !busy && in_op == ssf_pkg::OP_BUILD, busy)

endmodule

// File: sim/tb_sieve_spf_factorizer_top.sv
module tb_sieve_spf_factorizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_VALUE = 65535;
  localparam logic OP_FACTOR = ~ssf_pkg::OP_BUILD;
  localparam int unsigned SMALL_PRIMES [8] = '{2, 3, 5, 7, 11, 13, 17, 19};

  typedef struct packed {
    logic                      op;
    logic [ssf_pkg::VAL_W-1:0] value;
  } sieve_request_t;

  typedef struct packed {
    logic [ssf_pkg::VAL_W-1:0] prime;
    logic [ssf_pkg::EXP_W-1:0] exponent;
    logic                      last;
    logic [ssf_pkg::ST_W-1:0]  status;
  } factor_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_op = 1'b0;
  logic [ssf_pkg::VAL_W-1:0] in_value = '0;
  logic                      cfg_we = 1'b0;
  logic [ssf_pkg::VAL_W-1:0] cfg_wdata = '0;
  logic                      out_valid;
  logic [ssf_pkg::VAL_W-1:0] out_prime;
  logic [ssf_pkg::EXP_W-1:0] out_exponent;
  logic                      out_last;
  logic [ssf_pkg::ST_W-1:0]  out_status;

  // Local copy of the block's state.
  logic [ssf_pkg::VAL_W-1:0] spf_table [0:MAX_VALUE];
  bit                        table_ready = 1'b0;
  int unsigned               built_lim = 0;
  int unsigned               limit_setting = 65535;

  sieve_request_t   request_q[$];
  factor_result_t   awaited_results[$];
  int               gap_pct = 0;
  int               fail_count = 0;

  sieve_spf_factorizer_top #(
    .MAX_VALUE(MAX_VALUE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_value(in_value),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_prime(out_prime),
    .out_exponent(out_exponent),
    .out_last(out_last),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  function automatic factor_result_t result_of(input int unsigned prime,
                                               input int unsigned exponent,
                                               input logic last,
                                               input logic [ssf_pkg::ST_W-1:0] status);
    factor_result_t r;
    r.prime = ssf_pkg::VAL_W'(prime);
    r.exponent = ssf_pkg::EXP_W'(exponent);
    r.last = last;
    r.status = status;
    return r;
  endfunction

  function automatic void sieve_table_rebuild();
    int unsigned lim;
    int unsigned i;
    int unsigned p;
    int unsigned q;
    lim = (limit_setting > MAX_VALUE) ? MAX_VALUE : limit_setting;
    for (i = 0; i <= MAX_VALUE; i++) spf_table[i] = '0;
    if (lim >= 1) spf_table[1] = ssf_pkg::VAL_W'(1);
    for (p = 2; p <= lim; p++) begin
      if (spf_table[p] == 0) begin
        spf_table[p] = ssf_pkg::VAL_W'(p);
        for (q = 2 * p; q <= lim; q += p) begin
          if (spf_table[q] == 0) spf_table[q] = ssf_pkg::VAL_W'(p);
        end
      end
    end
    built_lim = lim;
    table_ready = 1'b1;
  endfunction

  // Works out every result that one accepted request causes.
  function automatic void resolve_request(input logic op,
                                          input logic [ssf_pkg::VAL_W-1:0] value);
    int unsigned n;
    int unsigned p;
    int unsigned e;
    int unsigned k;
    int unsigned i;
    int unsigned fp [ssf_pkg::MAX_RES];
    int unsigned fe [ssf_pkg::MAX_RES];
    n = 32'(value);
    k = 0;
    if (op == ssf_pkg::OP_BUILD) begin
      sieve_table_rebuild();
      awaited_results.push_back(result_of(0, 0, 1'b1, ssf_pkg::ST_DONE));
    end else if (!table_ready || (n > 1 && n > built_lim)) begin
      awaited_results.push_back(result_of(0, 0, 1'b1, ssf_pkg::ST_ERROR));
    end else if (n <= 1) begin
      awaited_results.push_back(result_of(0, 0, 1'b1, ssf_pkg::ST_EMPTY));
    end else begin
      while (n > 1 && k < ssf_pkg::MAX_RES) begin
        p = 32'(spf_table[n]);
        if (p < 2) break;
        e = 0;
        while (n % p == 0) begin
          n = n / p;
          e++;
        end
        fp[k] = p;
        fe[k] = e;
        k++;
      end
      if (k == 0) begin
        awaited_results.push_back(result_of(0, 0, 1'b1, ssf_pkg::ST_ERROR));
      end else begin
        for (i = 0; i < k; i++) begin
          awaited_results.push_back(result_of(fp[i], fe[i], i == k - 1,
                                              ssf_pkg::ST_FACTOR));
        end
      end
    end
  endfunction

  function automatic void check_field(input string name,
                                      input logic [ssf_pkg::VAL_W-1:0] want,
                                      input logic [ssf_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Request driver: holds start until the block takes the request.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) resolve_request(in_op, in_value);
      if (request_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_op <= request_q[0].op;
        in_value <= request_q[0].value;
        void'(request_q.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    factor_result_t want;
    if (rst_n && $isunknown(out_valid)) begin
      $error("out_valid is unknown");
      fail_count++;
    end else if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: prime %0d exponent %0d last %0d status %0d",
               out_prime, out_exponent, out_last, out_status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("prime", want.prime, out_prime);
        check_field("exponent", ssf_pkg::VAL_W'(want.exponent),
                    ssf_pkg::VAL_W'(out_exponent));
        check_field("last", ssf_pkg::VAL_W'(want.last), ssf_pkg::VAL_W'(out_last));
        check_field("status", ssf_pkg::VAL_W'(want.status), ssf_pkg::VAL_W'(out_status));
      end
    end
  end

  task automatic queue_request(input logic op, input logic [ssf_pkg::VAL_W-1:0] value);
    sieve_request_t r;
    r.op = op;
    r.value = value;
    request_q.push_back(r);
  endtask

  task automatic drain_requests();
    do @(negedge clk);
    while (request_q.size() != 0 || start || busy || awaited_results.size() != 0);
  endtask

  task automatic write_limit(input int unsigned lim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ssf_pkg::VAL_W'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    limit_setting = lim;
  endtask

  // Mix of in-range values, products of small primes (many distinct factors and
  // high exponents), zero and one, and values anywhere in the field.
  function automatic logic [ssf_pkg::VAL_W-1:0] pick_value(input int unsigned lim);
    int unsigned n;
    int unsigned sel;
    int unsigned p;
    sel = $urandom_range(99);
    if (sel < 55) begin
      n = $urandom_range(lim, 2);
    end else if (sel < 75) begin
      n = 1;
      repeat ($urandom_range(16, 1)) begin
        p = SMALL_PRIMES[$urandom_range(7)];
        if (n * p <= lim) n = n * p;
      end
    end else if (sel < 85) begin
      n = $urandom_range(1);
    end else begin
      n = $urandom_range(MAX_VALUE);
    end
    return ssf_pkg::VAL_W'(n);
  endfunction

  initial begin : stimulus
    int unsigned lim;
    int ph;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    gap_pct = 12;

    // Nothing built yet: every factorize request is refused.
    queue_request(OP_FACTOR, 16'd0);
    queue_request(OP_FACTOR, 16'hFFFF);
    drain_requests();

    // Smallest limit, then a limit change that must not apply before a rebuild.
    write_limit(2);
    queue_request(ssf_pkg::OP_BUILD, 16'hFFFF);
    queue_request(OP_FACTOR, 16'd1);
    queue_request(OP_FACTOR, 16'd2);
    queue_request(OP_FACTOR, 16'd3);
    drain_requests();
    write_limit(100);
    queue_request(OP_FACTOR, 16'd50);
    queue_request(ssf_pkg::OP_BUILD, 16'd0);
    queue_request(OP_FACTOR, 16'd97);
    queue_request(OP_FACTOR, 16'd100);
    drain_requests();

    // Full table: the one large build of the run.
    write_limit(65535);
    queue_request(ssf_pkg::OP_BUILD, 16'd0);
    queue_request(OP_FACTOR, 16'd65535);
    queue_request(OP_FACTOR, 16'd65521);
    queue_request(OP_FACTOR, 16'd30030);
    queue_request(OP_FACTOR, 16'd32768);
    queue_request(OP_FACTOR, 16'd65534);
    queue_request(OP_FACTOR, 16'd65025);
    queue_request(OP_FACTOR, 16'd0);
    repeat (160) queue_request(OP_FACTOR, pick_value(65535));

    // Small tables keep the rebuilds cheap.
    for (ph = 0; ph < 9; ph++) begin
      drain_requests();
      gap_pct = (ph < 4) ? 72 : 0;
      if (ph == 4) lim = 2;
      else if (ph == 8) lim = $urandom_range(5000, 2000);
      else lim = $urandom_range(700, 3);
      write_limit(lim);
      if ($urandom_range(9) != 0) queue_request(ssf_pkg::OP_BUILD, ssf_pkg::VAL_W'($urandom));
      repeat (40) begin
        if ($urandom_range(49) == 0) begin
          queue_request(ssf_pkg::OP_BUILD, ssf_pkg::VAL_W'($urandom));
        end else begin
          queue_request(OP_FACTOR, pick_value(lim));
        end
      end
    end

    drain_requests();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd80_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
